FILE: rtl/match_block_weighted_kernel_defines.svh
// assertion macros shared by the rtl
`ifndef MATCH_BLOCK_WEIGHTED_KERNEL_DEFINES_SVH
`define MATCH_BLOCK_WEIGHTED_KERNEL_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MBWK_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define MBWK_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/mbwk_pkg.sv
`default_nettype none

package mbwk_pkg;

   // sizing
   localparam int MAX_SEQ_LEN = 512;
   localparam int WEIGHT_BITS = 32;
   localparam int TABLE_DEPTH = 512;
   localparam int RUN_IDX_W   = $clog2(TABLE_DEPTH);
   localparam int RUN_CAP     = ((MAX_SEQ_LEN < TABLE_DEPTH) ? MAX_SEQ_LEN : TABLE_DEPTH) - 1;
   localparam int WT_W        = (WEIGHT_BITS < 32) ? WEIGHT_BITS : 32;
   localparam int ACC_W       = 48;
   localparam int DEG_W       = 10;

   // field widths
   localparam int CHAR_W      = 8;
   localparam int WIDX_W      = 9;
   localparam int WVAL_W      = 32;

   // csr port
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic REG_DEGREE_SELECT = 1'b0;

   typedef enum logic {
      CMD_COMPARE = 1'b0,
      CMD_WRITE   = 1'b1
   } mbwk_cmd_type;

   // item in the accumulate stage
   typedef struct packed {
      logic valid;
      logic add;
      logic last;
   } mbwk_stage_type;

endpackage

`default_nettype wire

FILE: rtl/mbwk_ifs.sv
`default_nettype none

interface mbwk_req_if;
   import mbwk_pkg::*;

   logic                valid;
   logic                ready;
   mbwk_cmd_type        cmd;
   logic [CHAR_W-1:0]   char_a;
   logic [CHAR_W-1:0]   char_b;
   logic                last_pair;
   logic [WIDX_W-1:0]   weight_index;
   logic [WVAL_W-1:0]   weight_value;

   modport source (output valid, cmd, char_a, char_b, last_pair, weight_index,
                   weight_value, input ready);
   modport sink   (input valid, cmd, char_a, char_b, last_pair, weight_index,
                   weight_value, output ready);
endinterface

interface mbwk_rsp_if;
   import mbwk_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACC_W-1:0]    kernel_sum;
   logic                saturated;

   modport source (output valid, kernel_sum, saturated, input ready);
   modport sink   (input valid, kernel_sum, saturated, output ready);
endinterface

`default_nettype wire

FILE: rtl/mbwk_ram.sv
`default_nettype none

module mbwk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/mbwk_run.sv
`default_nettype none

module mbwk_run (
   input  wire logic                            clock,
   input  wire logic                            reset,
   mbwk_req_if.sink                             req,
   input  wire logic                            stall,
   input  wire logic signed [mbwk_pkg::DEG_W-1:0] degree_select,
   output      logic                            wr_en,
   output      logic [mbwk_pkg::RUN_IDX_W-1:0]  wr_addr,
   output      logic [mbwk_pkg::WT_W-1:0]       wr_data,
   output      logic                            rd_en,
   output      logic [mbwk_pkg::RUN_IDX_W-1:0]  rd_addr,
   output      mbwk_pkg::mbwk_stage_type        stage
);
   import mbwk_pkg::*;

   logic                 run_open_ff;
   logic                 run_open_in;
   logic [RUN_IDX_W-1:0] run_idx_ff;
   logic [RUN_IDX_W-1:0] run_idx_in;
   mbwk_stage_type       stage_ff;
   mbwk_stage_type       stage_in;

   logic                 accept;
   logic                 compare;
   logic                 match;
   logic [RUN_IDX_W-1:0] grow_idx;
   logic                 close_now;
   logic [RUN_IDX_W-1:0] close_idx;
   logic                 take;

   assign req.ready = ~stall;
   assign accept    = req.valid & ~stall;
   assign compare   = accept & (req.cmd == CMD_COMPARE);
   assign match     = (req.char_a == req.char_b);

   // run index after a matching pair, held at the cap
   always_comb begin
      if (!run_open_ff) begin
         grow_idx = '0;
      end else if (run_idx_ff < RUN_IDX_W'(RUN_CAP)) begin
         grow_idx = run_idx_ff + 1'b1;
      end else begin
         grow_idx = run_idx_ff;
      end
   end

   // a run closes at a mismatch or at the last pair
   assign close_now = match ? req.last_pair : run_open_ff;
   assign close_idx = match ? grow_idx : run_idx_ff;
   assign take      = degree_select[DEG_W-1] |
                      (degree_select == $signed({{(DEG_W-RUN_IDX_W){1'b0}}, close_idx}));

   // weight fetch and weight write
   assign rd_en   = compare & close_now;
   assign rd_addr = close_idx;
   assign wr_en   = accept & (req.cmd == CMD_WRITE);
   assign wr_addr = req.weight_index[RUN_IDX_W-1:0];
   assign wr_data = req.weight_value[WT_W-1:0];

   // run tracking and stage handoff
   always_comb begin
      run_open_in = run_open_ff;
      run_idx_in  = run_idx_ff;
      if (compare) begin
         if (match && !req.last_pair) begin
            run_open_in = 1'b1;
            run_idx_in  = grow_idx;
         end else begin
            run_open_in = 1'b0;
         end
      end
      stage_in = stage_ff;
      if (!stall) begin
         stage_in.valid = compare;
         stage_in.add   = close_now & take;
         stage_in.last  = req.last_pair;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff    <= 1'b0;
         stage_ff.valid <= 1'b0;
      end else begin
         run_open_ff    <= run_open_in;
         stage_ff.valid <= stage_in.valid;
      end
      run_idx_ff     <= run_idx_in;
      stage_ff.add   <= stage_in.add;
      stage_ff.last  <= stage_in.last;
   end

   assign stage = stage_ff;

endmodule

`default_nettype wire

FILE: rtl/mbwk_acc.sv
`default_nettype none

module mbwk_acc (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire mbwk_pkg::mbwk_stage_type   stage,
   input  wire logic [mbwk_pkg::WT_W-1:0]  weight,
   output      logic                       stall,
   mbwk_rsp_if.source                      rsp
);
   import mbwk_pkg::*;

   logic [ACC_W-1:0] acc_ff;
   logic [ACC_W-1:0] acc_in;
   logic             sat_ff;
   logic             sat_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [ACC_W-1:0] rsp_sum_ff;
   logic [ACC_W-1:0] rsp_sum_in;
   logic             rsp_sat_ff;
   logic             rsp_sat_in;

   logic             fire;
   logic [ACC_W:0]   addend;
   logic [ACC_W:0]   sum;
   logic [ACC_W-1:0] acc_next;
   logic             sat_next;

   // a second result waits while the output beat is still held
   assign stall = stage.valid & stage.last & rsp_valid_ff & ~rsp.ready;
   assign fire  = stage.valid & ~stall;

   // saturating add of the fetched weight
   assign addend   = stage.add ? {{(ACC_W+1-WT_W){1'b0}}, weight} : '0;
   assign sum      = {1'b0, acc_ff} + addend;
   assign acc_next = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
   assign sat_next = sat_ff | sum[ACC_W];

   always_comb begin
      acc_in       = acc_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp.ready;
      rsp_sum_in   = rsp_sum_ff;
      rsp_sat_in   = rsp_sat_ff;
      if (fire) begin
         if (stage.last) begin
            rsp_valid_in = 1'b1;
            rsp_sum_in   = acc_next;
            rsp_sat_in   = sat_next;
            acc_in       = '0;
            sat_in       = 1'b0;
         end else begin
            acc_in = acc_next;
            sat_in = sat_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_sum_ff <= rsp_sum_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.kernel_sum = rsp_sum_ff;
   assign rsp.saturated  = rsp_sat_ff;

endmodule

`default_nettype wire

FILE: rtl/match_block_weighted_kernel.sv
// a last pair, once accepted, passes the stage register and then the result beat register
// throughput: one item per cycle when not stalled, set by one weight table read per run end
// a last pair stalls input only while the previous result beat is not taken
// reset: run, sum, saturation flag and output clear; degree_select goes to -1
// the weight table is not cleared and must be written before it is used
`default_nettype none

module match_block_weighted_kernel (
   input  wire logic                              clock,
   input  wire logic                              reset,
   mbwk_req_if.sink                               req_ch,
   mbwk_rsp_if.source                             rsp_ch,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [mbwk_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [mbwk_pkg::CSR_DATA_W-1:0]   pwdata,
   output      logic [mbwk_pkg::CSR_DATA_W-1:0]   prdata,
   output      logic                              pready
);
   import mbwk_pkg::*;

`include "match_block_weighted_kernel_defines.svh"

   logic signed [DEG_W-1:0] degree_ff;
   logic signed [DEG_W-1:0] degree_in;
   logic                    reg_hit;

   logic                    stall;
   mbwk_stage_type          stage;
   logic                    wr_en;
   logic [RUN_IDX_W-1:0]    wr_addr;
   logic [WT_W-1:0]         wr_data;
   logic                    rd_en;
   logic [RUN_IDX_W-1:0]    rd_addr;
   logic [WT_W-1:0]         rd_data;

   // csr decode, one register
   assign pready  = 1'b1;
   assign reg_hit = (paddr[2] == REG_DEGREE_SELECT);
   assign prdata  = reg_hit ? CSR_DATA_W'(degree_ff) : '0;

   always_comb begin
      degree_in = degree_ff;
      if (psel && penable && pwrite && pready && reg_hit) begin
         degree_in = pwdata[DEG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= '1;
      end else begin
         degree_ff <= degree_in;
      end
   end

   // run tracking and weight fetch
   mbwk_run u_run (
      .clock         (clock),
      .reset         (reset),
      .req           (req_ch),
      .stall         (stall),
      .degree_select (degree_ff),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .stage         (stage)
   );

   // weight table
   mbwk_ram #(
      .WIDTH (WT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_weights (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // accumulate and result beat
   mbwk_acc u_acc (
      .clock  (clock),
      .reset  (reset),
      .stage  (stage),
      .weight (rd_data),
      .stall  (stall),
      .rsp    (rsp_ch)
   );

   // checks
   `MBWK_ASSERT_NOW(a_stall_blocks_input, stall, !req_ch.ready, "input taken during stall")
   `MBWK_ASSERT_NEXT(a_last_gives_beat, stage.valid && stage.last && !stall, rsp_ch.valid, "no result beat after last pair")
   `MBWK_ASSERT_NOW(a_sat_means_max, rsp_ch.valid && rsp_ch.saturated, rsp_ch.kernel_sum == {ACC_W{1'b1}}, "saturated result below max")
   `MBWK_ASSERT_NEXT(a_write_no_stage, req_ch.valid && req_ch.ready && req_ch.cmd == CMD_WRITE, !stage.valid, "weight write entered accumulate stage")

endmodule

`default_nettype wire

FILE: tb/sv/mbwk_kernel_checker.sv
`timescale 1ns / 100ps

module mbwk_kernel_checker
   import mbwk_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   mbwk_req_if                        req_mon,
   mbwk_rsp_if                        rsp_mon,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic                  pready,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output int                         mismatch_count,
   output int                         pending_results
);

   localparam logic [CSR_ADDR_W-1:0] DEGREE_ADDR = CSR_ADDR_W'(4 * REG_DEGREE_SELECT);

   typedef struct packed {
      logic [ACC_W-1:0] kernel_sum;
      logic             saturated;
   } kernel_result_type;

   // shadow of the block state
   logic [WT_W-1:0]         weight_shadow [TABLE_DEPTH];
   logic signed [DEG_W-1:0] degree_shadow;
   int                      open_run;
   logic [ACC_W-1:0]        sum_shadow;
   logic                    sat_shadow;
   kernel_result_type       pending_sums [$];
   int                      fails = 0;
   int                      waiting = 0;

   assign mismatch_count  = fails;
   assign pending_results = waiting;

   // add the weight of the run that just ended, saturating at full scale
   task automatic score_closed_run();
      logic [ACC_W:0] total;
      if (open_run >= 0) begin
         if (degree_shadow < 0 || open_run == int'(degree_shadow)) begin
            total = {1'b0, sum_shadow} + (ACC_W + 1)'(weight_shadow[open_run]);
            if (total[ACC_W]) begin
               sum_shadow = '1;
               sat_shadow = 1'b1;
            end else begin
               sum_shadow = total[ACC_W-1:0];
            end
         end
      end
      open_run = -1;
   endtask

   always @(posedge clock) begin : watch
      kernel_result_type oldest;
      if (reset) begin
         degree_shadow = -1;
         open_run      = -1;
         sum_shadow    = '0;
         sat_shadow    = 1'b0;
         pending_sums.delete();
      end else begin
         // register write
         if (psel && penable && pwrite && pready && paddr == DEGREE_ADDR)
            degree_shadow = pwdata[DEG_W-1:0];

         // request beat
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.cmd == CMD_WRITE) begin
               weight_shadow[req_mon.weight_index] = req_mon.weight_value[WT_W-1:0];
            end else begin
               if (req_mon.char_a == req_mon.char_b) begin
                  if (open_run < RUN_CAP)
                     open_run++;
               end else begin
                  score_closed_run();
               end
               if (req_mon.last_pair) begin
                  score_closed_run();
                  pending_sums.push_back('{sum_shadow, sat_shadow});
                  sum_shadow = '0;
                  sat_shadow = 1'b0;
               end
            end
         end

         // result beat
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_sums.size() == 0) begin
               $error("unexpected result beat: kernel_sum %0h saturated %0b",
                      rsp_mon.kernel_sum, rsp_mon.saturated);
               fails++;
            end else begin
               oldest = pending_sums.pop_front();
               if (rsp_mon.kernel_sum !== oldest.kernel_sum) begin
                  $error("kernel_sum mismatch: expected %0h, got %0h",
                         oldest.kernel_sum, rsp_mon.kernel_sum);
                  fails++;
               end
               if (rsp_mon.saturated !== oldest.saturated) begin
                  $error("saturated mismatch: expected %0b, got %0b",
                         oldest.saturated, rsp_mon.saturated);
                  fails++;
               end
            end
         end
      end
      waiting = pending_sums.size();
   end

endmodule

FILE: tb/sv/tb_match_block_weighted_kernel.sv
`timescale 1ns / 100ps

module tb_match_block_weighted_kernel;
   import mbwk_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam logic [CSR_ADDR_W-1:0] DEGREE_ADDR = CSR_ADDR_W'(4 * REG_DEGREE_SELECT);

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    mismatch_count;
   int                    pending_results;
   int                    cycle_count = 0;
   int                    idle_pct = 0;
   int                    stall_left = 0;

   mbwk_req_if req_bus ();
   mbwk_rsp_if rsp_bus ();

   match_block_weighted_kernel DUT (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_bus),
      .rsp_ch  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   mbwk_kernel_checker kernel_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .pready          (pready),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("match_block_weighted_kernel verification failed");
      $finish;
   end

   // result side back-pressure in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= $urandom_range(5);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   function automatic logic [WVAL_W-1:0] random_weight();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // one request beat, with an optional gap ahead of it
   task automatic put_beat(input mbwk_cmd_type cmd, input logic [CHAR_W-1:0] a,
                           input logic [CHAR_W-1:0] b, input logic last,
                           input logic [WIDX_W-1:0] idx, input logic [WVAL_W-1:0] val);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.cmd          <= cmd;
      req_bus.char_a       <= a;
      req_bus.char_b       <= b;
      req_bus.last_pair    <= last;
      req_bus.weight_index <= idx;
      req_bus.weight_value <= val;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic put_pair(input logic [CHAR_W-1:0] a, input logic [CHAR_W-1:0] b,
                           input logic last);
      put_beat(CMD_COMPARE, a, b, last, WIDX_W'($urandom), $urandom);
   endtask

   task automatic put_weight(input logic [WIDX_W-1:0] idx, input logic [WVAL_W-1:0] val);
      put_beat(CMD_WRITE, CHAR_W'($urandom), CHAR_W'($urandom), 1'($urandom), idx, val);
   endtask

   // one sequence pair with random content and scattered weight writes
   task automatic put_sequence(input int pairs, input bit wide_chars);
      logic [CHAR_W-1:0] a;
      logic [CHAR_W-1:0] b;
      for (int i = 0; i < pairs; i++) begin
         if ($urandom_range(99) < 4)
            put_weight(WIDX_W'($urandom), random_weight());
         a = wide_chars ? CHAR_W'($urandom) : CHAR_W'($urandom_range(3));
         if ($urandom_range(99) < 70)
            b = a;
         else
            b = wide_chars ? CHAR_W'($urandom) : CHAR_W'($urandom_range(3));
         put_pair(a, b, i == pairs - 1);
      end
   endtask

   // one unbroken run of equal pairs closed by the last pair
   task automatic put_long_run(input int pairs);
      logic [CHAR_W-1:0] c;
      c = CHAR_W'($urandom);
      for (int i = 0; i < pairs; i++)
         put_pair(c, c, i == pairs - 1);
   endtask

   // stop sending and let every pending result drain
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_degree(input int value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= DEGREE_ADDR;
      pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   initial begin : stimulus
      int degree_plan [8];
      int gap_plan [8];
      int sent;
      int seq_len;

      // all inputs known from time zero
      reset                = 1'b1;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      req_bus.valid        = 1'b0;
      req_bus.cmd          = CMD_COMPARE;
      req_bus.char_a       = '0;
      req_bus.char_b       = '0;
      req_bus.last_pair    = 1'b0;
      req_bus.weight_index = '0;
      req_bus.weight_value = '0;
      rsp_bus.ready        = 1'b0;

      degree_plan = '{-1, 0, 511, -512, 1, 2, $urandom_range(3, 8), -1};
      gap_plan    = '{0, 20, 40, 15, 0, 30, 10, 25};

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // fill the whole weight table so no run can read an unset entry
      for (int i = 0; i < TABLE_DEPTH; i++)
         put_weight(WIDX_W'(i), random_weight());

      // directed: field extremes, writes inside a sequence, empty runs
      put_pair(8'h00, 8'h00, 1'b1);
      put_pair(8'h00, 8'hFF, 1'b1);
      put_weight(9'h1FF, 32'hFFFF_FFFF);
      put_weight(9'h000, 32'h0000_0000);
      put_pair(8'hFF, 8'hFF, 1'b0);
      put_pair(8'hFF, 8'hFF, 1'b0);
      put_pair(8'h12, 8'h34, 1'b0);
      put_beat(CMD_WRITE, 8'hFF, 8'hFF, 1'b1, 9'h001, 32'h0001_0000);
      put_pair(8'hAA, 8'hAA, 1'b0);
      put_weight(9'h002, 32'h0000_0001);
      put_pair(8'hAA, 8'hAA, 1'b0);
      put_pair(8'hAA, 8'hAA, 1'b0);
      put_pair(8'h55, 8'hAA, 1'b0);
      put_pair(8'h77, 8'h77, 1'b0);
      put_pair(8'h77, 8'h77, 1'b1);
      put_pair(8'h01, 8'h80, 1'b0);
      put_pair(8'hFE, 8'h7F, 1'b1);

      // random phases over several selector settings and idling levels
      for (int p = 0; p < 8; p++) begin
         settle();
         idle_pct = gap_plan[p];
         write_degree(degree_plan[p]);
         // a run longer than the cap scores the last table entry
         if (degree_plan[p] == 511)
            put_long_run(530);
         sent = 0;
         while (sent < 96) begin
            seq_len = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
            put_sequence(seq_len, $urandom_range(3) == 0);
            sent += seq_len;
         end
      end

      // final part without idling
      settle();
      idle_pct = 0;
      write_degree(-1);
      put_weight(9'h000, 32'hFFFF_FFFF);
      put_pair(8'h3C, 8'h3C, 1'b1);
      put_pair(8'h3C, 8'h3C, 1'b1);
      put_sequence(12, 1'b1);

      settle();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0)
         $display("match_block_weighted_kernel verification clean");
      else
         $display("match_block_weighted_kernel verification failed");
      $finish;
   end

endmodule
